// ===== hdl/mss_pkg.sv =====
`timescale 1ns / 1ps
package mss_pkg;

    localparam int DATA_W     = 16;
    localparam int FRAC_W     = 12;
    localparam int ACC_W      = 32;
    localparam int IDX_W      = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CLS_W      = 6;
    localparam int PROB_W     = 16;
    localparam int EXP_W      = 17;
    localparam int EXP_ACC_W  = 33;
    localparam int EXP_STEPS  = 8;
    localparam int DIV_NUM_W  = 33;
    localparam int DIV_DEN_W  = 23;
    localparam int SUM_W      = 23;
    localparam int NUM_W_REGS = 4;

    localparam logic [CFG_W-1:0] MAX_WIDTH = 11'd1024;

    // request codes
    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_BIAS   = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LAYERS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOURTH_WIDTH = 3'd4;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [1:0]              layer_sel;
        logic [IDX_W-1:0]        src_index;
        logic [IDX_W-1:0]        dst_index;
        logic signed [DATA_W-1:0] value;
        logic                    last_sample;
    } t_req;

    typedef struct packed {
        logic [CLS_W-1:0]  class_index;
        logic [PROB_W-1:0] probability;
        logic              last;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BIAS,
        S_LOAD,
        S_MAC,
        S_DRAIN,
        S_SIG_EXP,
        S_SIG_DIV,
        S_MAX,
        S_MAX_END,
        S_EXP_RD,
        S_EXP_GO,
        S_EXP_WAIT,
        S_DIV_RD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    // exp(-2^j/16) in Q0.32
    function automatic logic [31:0] exp_factor(input int j);
        logic [31:0] f;
        case (j)
            0:       f = 32'd4034748382;
            1:       f = 32'd3790295335;
            2:       f = 32'd3344923893;
            3:       f = 32'd2605029347;
            4:       f = 32'd1580030169;
            5:       f = 32'd581260615;
            6:       f = 32'd78665070;
            7:       f = 32'd1440801;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== hdl/mss_stream_if.sv =====
`timescale 1ns / 1ps
interface mss_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mss_ram.sv =====
`timescale 1ns / 1ps
module mss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/mss_exp_cell.sv =====
`timescale 1ns / 1ps
module mss_exp_cell #(
    parameter int STEP = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [mss_pkg::EXP_STEPS-1:0]  i_k,
    input  logic [mss_pkg::EXP_ACC_W-1:0]  i_acc,
    output logic                           o_valid,
    output logic [mss_pkg::EXP_STEPS-1:0]  o_k,
    output logic [mss_pkg::EXP_ACC_W-1:0]  o_acc
);
    localparam logic [31:0] FACTOR = mss_pkg::exp_factor(STEP);

    logic [64:0]                      w_prod;
    logic [64:0]                      w_round;
    logic [mss_pkg::EXP_ACC_W-1:0]    n_acc;
    logic                             r_valid;
    logic [mss_pkg::EXP_STEPS-1:0]    r_k;
    logic [mss_pkg::EXP_ACC_W-1:0]    r_acc;

    // one factor per cell, rounded to nearest Q0.32
    always_comb begin
        w_prod  = {32'd0, i_acc} * {33'd0, FACTOR};
        w_round = w_prod + (65'd1 << 31);
        n_acc   = i_k[STEP] ? w_round[64:32] : i_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= i_k;
        r_acc <= n_acc;
    end

    assign o_valid = r_valid;
    assign o_k     = r_k;
    assign o_acc   = r_acc;
endmodule

// ===== hdl/mss_exp_chain.sv =====
`timescale 1ns / 1ps
module mss_exp_chain (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [31:0]                  i_d,
    output logic                         o_valid,
    output logic [mss_pkg::EXP_W-1:0]    o_e
);
    localparam int N = mss_pkg::EXP_STEPS;

    logic                            s_valid [0:N];
    logic [N-1:0]                    s_k     [0:N];
    logic [mss_pkg::EXP_ACC_W-1:0]   s_acc   [0:N];
    logic [mss_pkg::EXP_ACC_W-1:0]   w_round;

    // d is Q8.24; step index is d in 1/16 units, beyond 255 the result is zero
    assign s_valid[0] = i_start;
    assign s_k[0]     = i_d[27:20];
    assign s_acc[0]   = (i_d[31:28] != 4'd0) ? '0 : (33'd1 << 32);

    for (genvar g = 0; g < N; g++) begin : g_cell
        mss_exp_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .i_k     (s_k[g]),
            .i_acc   (s_acc[g]),
            .o_valid (s_valid[g+1]),
            .o_k     (s_k[g+1]),
            .o_acc   (s_acc[g+1])
        );
    end

    assign w_round = s_acc[N] + 33'd32768;
    assign o_valid = s_valid[N];
    assign o_e     = w_round[32:16];
endmodule

// ===== hdl/mss_divider.sv =====
`timescale 1ns / 1ps
module mss_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mss_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [mss_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                            o_done,
    output logic [mss_pkg::DIV_NUM_W-1:0]   o_quo
);
    localparam int NW    = mss_pkg::DIV_NUM_W;
    localparam int DW    = mss_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NW-1:0]     r_quo;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [DW:0]       w_trial;
    logic [DW:0]       w_diff;
    logic              w_ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[NW-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== hdl/mlp_sigmoid_softmax_inference.sv =====
`timescale 1ns / 1ps
// Fixed-point forward pass of a fully connected network, sigmoid hidden
// layers, softmax output.
// Channels: i_req takes requests (weight write, bias write, input sample);
// o_res returns one probability per output class, in class order, with
// last set on the final class. Config registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while
// the block is idle, which the block itself leaves unchecked. Weight, bias
// and non-final sample requests are taken whenever offered while idle. A
// sample with last_sample set starts a pass; i_req is held off until every
// result is loaded into the output register. Per neuron the pass runs one
// MAC a cycle over the weight RAM port, then drains; hidden neurons then
// take sigmoid through the 8-cell exp chain and the divider. Softmax scans
// the logits for the max, runs exp per class, then divides and loads each.
// Reset: synchronous, clears the control state and loads the register
// defaults (3 layers, widths 784/128/10/10). Stores are not cleared.
// A stalled receiver holds the current result in the output register; the
// pass waits before loading the next class.
module mlp_sigmoid_softmax_inference #(
    parameter int MAX_LAYERS = 4,
    parameter int MAX_OUT    = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mss_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mss_pkg::CFG_W-1:0]          i_cfg_data,
    mss_stream_if.sink                         i_req,
    mss_stream_if.source                       o_res
);
    localparam int LU      = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
    localparam int W_DEPTH = (LU - 1) * 1048576;
    localparam int WA_W    = $clog2(W_DEPTH);
    localparam int B_DEPTH = (LU - 1) * 1024;
    localparam int BA_W    = $clog2(B_DEPTH);
    localparam int A_DEPTH = 2048;
    localparam int AA_W    = $clog2(A_DEPTH);
    localparam int OW      = $clog2(MAX_OUT);
    localparam logic [mss_pkg::CFG_W-1:0] OUT_CAP = 11'(MAX_OUT);
    localparam logic [2:0] N_MAX = 3'(LU);

    // width clamp: 0 reads as 1, beyond the store as its size, output capped
    function automatic logic [10:0] f_clamp(input logic [10:0] w, input logic last);
        logic [10:0] c;
        c = w;
        if (c == 11'd0) c = 11'd1;
        if (c > mss_pkg::MAX_WIDTH) c = mss_pkg::MAX_WIDTH;
        if (last && c > OUT_CAP) c = OUT_CAP;
        return c;
    endfunction

    // ---------------- registers ----------------
    mss_pkg::t_state          r_state, n_state;
    logic [2:0]               r_num_layers;
    logic [10:0]              r_width [0:3];
    logic [1:0]               r_l;
    logic [10:0]              r_j;
    logic [10:0]              r_k;
    logic                     r_v1, r_v2;
    logic                     r_lv;
    logic                     r_first;
    logic signed [31:0]       r_prod;
    logic signed [31:0]       r_acc;
    logic signed [31:0]       r_mx;
    logic [mss_pkg::SUM_W-1:0] r_sum;
    logic [15:0]              r_p;
    logic                     r_ovalid;
    mss_pkg::t_res            r_out;

    // ---------------- memory ports ----------------
    logic                     c_w_we;
    logic [WA_W-1:0]          c_w_waddr, c_w_raddr;
    logic [15:0]              w_w_rdata;
    logic                     c_b_we;
    logic [BA_W-1:0]          c_b_waddr, c_b_raddr;
    logic [15:0]              w_b_rdata;
    logic                     c_a_we;
    logic [AA_W-1:0]          c_a_waddr, c_a_raddr;
    logic [15:0]              c_a_wdata, w_a_rdata;
    logic                     c_lg_we;
    logic [31:0]              w_lg_rdata;
    logic                     c_e_we;
    logic [mss_pkg::EXP_W-1:0] w_e_rdata;

    // ---------------- shared units ----------------
    logic                     c_exp_start;
    logic [31:0]              c_exp_d;
    logic                     w_exp_valid;
    logic [mss_pkg::EXP_W-1:0] w_exp_e;
    logic                     c_div_start;
    logic [mss_pkg::DIV_NUM_W-1:0] c_div_num;
    logic [mss_pkg::DIV_DEN_W-1:0] c_div_den;
    logic                     w_div_done;
    logic [mss_pkg::DIV_NUM_W-1:0] w_div_quo;

    // ---------------- layer bookkeeping ----------------
    logic [2:0]   c_n, c_last;
    logic [1:0]   c_lm1;
    logic [10:0]  c_wp, c_wc, c_wl;
    logic         c_is_out, c_j_last, c_k_last, c_sj_last;
    logic         c_pipe_empty, c_in_acc, c_load_out, c_neuron_done;
    logic [21:0]  c_w_full_wr, c_w_full_rd;
    logic [11:0]  c_b_full_wr, c_b_full_rd;
    logic [32:0]  c_sum33, c_neg33, c_diff33;
    logic [17:0]  c_den_sig;
    logic [12:0]  c_sig_s;
    logic         c_w_ok, c_b_ok;

    always_comb begin
        c_n = r_num_layers;
        if (c_n < 3'd2) c_n = 3'd2;
        if (c_n > N_MAX) c_n = N_MAX;
        c_last    = c_n - 3'd1;
        c_lm1     = r_l - 2'd1;
        c_is_out  = ({1'b0, r_l} == c_last);
        c_wp      = f_clamp(r_width[c_lm1], 1'b0);
        c_wc      = f_clamp(r_width[r_l], c_is_out);
        c_wl      = f_clamp(r_width[c_last[1:0]], 1'b1);
        c_j_last  = (r_j == c_wc - 11'd1);
        c_k_last  = (r_k == c_wp - 11'd1);
        c_sj_last = (r_j == c_wl - 11'd1);
        c_pipe_empty = !r_v1 && !r_v2;
        c_in_acc  = i_req.valid && i_req.ready;
        c_load_out = (r_state == mss_pkg::S_EMIT) && (!r_ovalid || o_res.ready);
    end

    // saturating accumulate, |acc| and softmax offset
    always_comb begin
        c_sum33  = {r_acc[31], r_acc} + {r_prod[31], r_prod};
        c_neg33  = 33'd0 - {r_acc[31], r_acc};
        c_diff33 = {r_mx[31], r_mx} - {w_lg_rdata[31], w_lg_rdata};
        c_den_sig = 18'd65536 + 18'(w_exp_e);
        c_sig_s  = w_div_quo[12:0];
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mss_pkg::S_IDLE: begin
                if (c_in_acc && i_req.data.req_type == mss_pkg::REQ_SAMPLE
                    && i_req.data.last_sample) n_state = mss_pkg::S_BIAS;
            end
            mss_pkg::S_BIAS:  n_state = mss_pkg::S_LOAD;
            mss_pkg::S_LOAD:  n_state = mss_pkg::S_MAC;
            mss_pkg::S_MAC: begin
                if (c_k_last) n_state = mss_pkg::S_DRAIN;
            end
            mss_pkg::S_DRAIN: begin
                if (c_pipe_empty) begin
                    if (!c_is_out) n_state = mss_pkg::S_SIG_EXP;
                    else if (!c_j_last) n_state = mss_pkg::S_BIAS;
                    else n_state = mss_pkg::S_MAX;
                end
            end
            mss_pkg::S_SIG_EXP: begin
                if (w_exp_valid) n_state = mss_pkg::S_SIG_DIV;
            end
            mss_pkg::S_SIG_DIV: begin
                if (w_div_done) n_state = mss_pkg::S_BIAS;
            end
            mss_pkg::S_MAX: begin
                if (c_sj_last) n_state = mss_pkg::S_MAX_END;
            end
            mss_pkg::S_MAX_END: begin
                if (!r_lv) n_state = mss_pkg::S_EXP_RD;
            end
            mss_pkg::S_EXP_RD: n_state = mss_pkg::S_EXP_GO;
            mss_pkg::S_EXP_GO: n_state = mss_pkg::S_EXP_WAIT;
            mss_pkg::S_EXP_WAIT: begin
                if (w_exp_valid) n_state = c_sj_last ? mss_pkg::S_DIV_RD : mss_pkg::S_EXP_RD;
            end
            mss_pkg::S_DIV_RD: n_state = mss_pkg::S_DIV_GO;
            mss_pkg::S_DIV_GO: n_state = mss_pkg::S_DIV_WAIT;
            mss_pkg::S_DIV_WAIT: begin
                if (w_div_done) n_state = mss_pkg::S_EMIT;
            end
            mss_pkg::S_EMIT: begin
                if (c_load_out) n_state = c_sj_last ? mss_pkg::S_IDLE : mss_pkg::S_DIV_RD;
            end
            default: n_state = mss_pkg::S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        // load-side writes, only taken while idle
        c_w_ok = ({1'b0, i_req.data.layer_sel} < 3'(LU - 1));
        c_b_ok = (i_req.data.layer_sel != 2'd0) && ({1'b0, i_req.data.layer_sel} < N_MAX);
        c_w_full_wr = {i_req.data.layer_sel, i_req.data.src_index, i_req.data.dst_index};
        c_b_full_wr = {i_req.data.layer_sel - 2'd1, i_req.data.dst_index};
        c_w_we    = c_in_acc && (i_req.data.req_type == mss_pkg::REQ_WEIGHT) && c_w_ok;
        c_w_waddr = c_w_full_wr[WA_W-1:0];
        c_b_we    = c_in_acc && (i_req.data.req_type == mss_pkg::REQ_BIAS) && c_b_ok;
        c_b_waddr = c_b_full_wr[BA_W-1:0];

        // pass-side reads
        c_w_full_rd = {c_lm1, r_k[9:0], r_j[9:0]};
        c_w_raddr   = c_w_full_rd[WA_W-1:0];
        c_b_full_rd = {c_lm1, r_j[9:0]};
        c_b_raddr   = c_b_full_rd[BA_W-1:0];
        c_a_raddr   = {c_lm1[0], r_k[9:0]};

        c_neuron_done = ((r_state == mss_pkg::S_DRAIN) && c_pipe_empty && c_is_out)
                     || ((r_state == mss_pkg::S_SIG_DIV) && w_div_done);

        // activation bank: samples into bank 0, hidden layer l into bank l mod 2
        if (r_state == mss_pkg::S_IDLE) begin
            c_a_we    = c_in_acc && (i_req.data.req_type == mss_pkg::REQ_SAMPLE);
            c_a_waddr = {1'b0, i_req.data.src_index};
            c_a_wdata = i_req.data.value;
        end else begin
            c_a_we    = (r_state == mss_pkg::S_SIG_DIV) && w_div_done;
            c_a_waddr = {r_l[0], r_j[9:0]};
            c_a_wdata = r_acc[31] ? 16'(13'd4096 - c_sig_s) : 16'(c_sig_s);
        end

        c_lg_we = (r_state == mss_pkg::S_DRAIN) && c_pipe_empty && c_is_out;
        c_e_we  = (r_state == mss_pkg::S_EXP_WAIT) && w_exp_valid;

        // exp chain: |z| for sigmoid, max - logit for softmax
        c_exp_start = ((r_state == mss_pkg::S_DRAIN) && c_pipe_empty && !c_is_out)
                   || (r_state == mss_pkg::S_EXP_GO);
        if (r_state == mss_pkg::S_EXP_GO) begin
            c_exp_d = c_diff33[31:0];
        end else begin
            c_exp_d = r_acc[31] ? c_neg33[31:0] : r_acc[31:0];
        end

        // divider: 2^28 + den/2 over den for sigmoid, e << 16 over sum for softmax
        c_div_start = ((r_state == mss_pkg::S_SIG_EXP) && w_exp_valid)
                   || (r_state == mss_pkg::S_DIV_GO);
        if (r_state == mss_pkg::S_DIV_GO) begin
            c_div_num = {w_e_rdata, 16'd0};
            c_div_den = r_sum;
        end else begin
            c_div_num = 33'(29'd268435456 + 29'(c_den_sig[17:1]));
            c_div_den = 23'(c_den_sig);
        end
    end

    assign i_req.ready = (r_state == mss_pkg::S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mss_pkg::S_IDLE;
            r_num_layers <= 3'd3;
            r_width[0]   <= 11'd784;
            r_width[1]   <= 11'd128;
            r_width[2]   <= 11'd10;
            r_width[3]   <= 11'd10;
            r_l          <= 2'd1;
            r_j          <= '0;
            r_k          <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_lv         <= 1'b0;
            r_first      <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mss_pkg::CFG_NUM_LAYERS:   r_num_layers <= i_cfg_data[2:0];
                    mss_pkg::CFG_INPUT_WIDTH:  r_width[0]   <= i_cfg_data;
                    mss_pkg::CFG_SECOND_WIDTH: r_width[1]   <= i_cfg_data;
                    mss_pkg::CFG_THIRD_WIDTH:  r_width[2]   <= i_cfg_data;
                    mss_pkg::CFG_FOURTH_WIDTH: r_width[3]   <= i_cfg_data;
                    default: ;
                endcase
            end

            r_v1 <= (r_state == mss_pkg::S_MAC);
            r_v2 <= r_v1;
            r_lv <= (r_state == mss_pkg::S_MAX);
            if (r_lv) r_first <= 1'b0;

            if (r_state == mss_pkg::S_IDLE && n_state == mss_pkg::S_BIAS) begin
                r_l <= 2'd1;
                r_j <= '0;
            end
            if (r_state == mss_pkg::S_LOAD) r_k <= '0;
            if (r_state == mss_pkg::S_MAC)  r_k <= r_k + 11'd1;

            if (c_neuron_done) begin
                if (c_j_last) begin
                    r_j <= '0;
                    if (!c_is_out) r_l <= r_l + 2'd1;
                    else r_first <= 1'b1;
                end else begin
                    r_j <= r_j + 11'd1;
                end
            end

            if ((r_state == mss_pkg::S_MAX)
                || (r_state == mss_pkg::S_EXP_WAIT && w_exp_valid)
                || c_load_out) begin
                r_j <= c_sj_last ? 11'd0 : r_j + 11'd1;
            end

            if (c_load_out) r_ovalid <= 1'b1;
            else if (o_res.ready) r_ovalid <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_w_rdata) * $signed(w_a_rdata);

        if (r_state == mss_pkg::S_LOAD) begin
            r_acc <= {{4{w_b_rdata[15]}}, w_b_rdata, 12'd0};
        end else if (r_v2) begin
            if (c_sum33[32] != c_sum33[31]) begin
                r_acc <= c_sum33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                r_acc <= c_sum33[31:0];
            end
        end

        if (r_lv && (r_first || $signed(w_lg_rdata) > r_mx)) r_mx <= w_lg_rdata;

        if (r_state == mss_pkg::S_MAX && r_first) r_sum <= '0;
        else if (c_e_we) r_sum <= r_sum + mss_pkg::SUM_W'(w_exp_e);

        if (r_state == mss_pkg::S_DIV_WAIT && w_div_done) begin
            r_p <= (w_div_quo > 33'd65535) ? 16'hffff : w_div_quo[15:0];
        end

        if (c_load_out) begin
            r_out.class_index <= r_j[5:0];
            r_out.probability <= r_p;
            r_out.last        <= c_sj_last;
        end
    end

    // ---------------- stores ----------------
    mss_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight_ram (
        .i_clk(i_clk), .i_we(c_w_we), .i_waddr(c_w_waddr), .i_wdata(i_req.data.value),
        .i_raddr(c_w_raddr), .o_rdata(w_w_rdata)
    );

    mss_ram #(.WIDTH(16), .DEPTH(B_DEPTH)) u_bias_ram (
        .i_clk(i_clk), .i_we(c_b_we), .i_waddr(c_b_waddr), .i_wdata(i_req.data.value),
        .i_raddr(c_b_raddr), .o_rdata(w_b_rdata)
    );

    mss_ram #(.WIDTH(16), .DEPTH(A_DEPTH)) u_act_ram (
        .i_clk(i_clk), .i_we(c_a_we), .i_waddr(c_a_waddr), .i_wdata(c_a_wdata),
        .i_raddr(c_a_raddr), .o_rdata(w_a_rdata)
    );

    mss_ram #(.WIDTH(32), .DEPTH(MAX_OUT)) u_logit_ram (
        .i_clk(i_clk), .i_we(c_lg_we), .i_waddr(r_j[OW-1:0]), .i_wdata(r_acc),
        .i_raddr(r_j[OW-1:0]), .o_rdata(w_lg_rdata)
    );

    mss_ram #(.WIDTH(mss_pkg::EXP_W), .DEPTH(MAX_OUT)) u_exp_ram (
        .i_clk(i_clk), .i_we(c_e_we), .i_waddr(r_j[OW-1:0]), .i_wdata(w_exp_e),
        .i_raddr(r_j[OW-1:0]), .o_rdata(w_e_rdata)
    );

    // ---------------- shared arithmetic ----------------
    mss_exp_chain u_exp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(c_exp_start), .i_d(c_exp_d),
        .o_valid(w_exp_valid), .o_e(w_exp_e)
    );

    mss_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(c_div_start), .i_num(c_div_num),
        .i_den(c_div_den), .o_done(w_div_done), .o_quo(w_div_quo)
    );
endmodule
